// ===== src/multichannel_biquad_df2_filter_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the multichannel biquad filter
// Each macro checks one implication on the rising edge of clk.
// It is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_BIQUAD_DF2_FILTER_ASSERT_SVH
`define MULTICHANNEL_BIQUAD_DF2_FILTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCBQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MCBQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mcbq_pkg.sv =====
// ----------------------------------------------------------------------------
// mcbq_pkg
// Shared types, register indexes and fixed-point helpers of the biquad filter.
// ----------------------------------------------------------------------------
package mcbq_pkg;

    localparam int COEF_W = 32;
    localparam int PROD_W = 64;
    localparam int RND_W  = 40;
    localparam int ACC_W  = 42;
    localparam int CONV_W = 50;
    localparam int CFG_IDX_W = 3;
    localparam int SEL_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

    localparam logic signed [COEF_W-1:0] B0_RESET = 32'sd16777216;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_FB   = 5'b00010,
        ST_W    = 5'b00100,
        ST_FF   = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

    // Q16.48 product to Q18.24, round to nearest with ties toward plus infinity.
    function automatic logic signed [ACC_W-1:0] round_q24(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = p + 64'sd8388608;
        return {{(ACC_W-RND_W){t[PROD_W-1]}}, t[PROD_W-1:24]};
    endfunction

endpackage

// ===== src/multichannel_biquad_df2_filter.sv =====
// ----------------------------------------------------------------------------
// multichannel_biquad_df2_filter
// Direct form II biquad with per-channel delay words held in a memory.
// ----------------------------------------------------------------------------
// Usage:
// A sample transaction on req_valid/req_stall carries sample_in and
// channel_sel; each one yields exactly one transaction on rsp_valid/rsp_stall
// carrying sample_out. Channel numbers at or above CHANNELS wrap modulo CHANNELS.
// One sample is in work at a time, and a new one is taken only once the last
// has reached its final step: the delay word read, two feedback products, the
// state write-back and the final sum run in sequence on two shared
// multipliers. While the receiver stalls, the finished result waits in the
// output register and the next sample is still taken; that sample then holds
// in its last step until the register frees.
// Coefficients are written on cfg_valid/cfg_ready (always ready), by index
// b0, b1, b2, a1, a2; other indexes are ignored. Write them only while idle.
// Reset sets b0 to one, the other coefficients to zero, and makes all delay
// words of every channel read as zero at once.
// ----------------------------------------------------------------------------
`include "multichannel_biquad_df2_filter_assert.svh"

module multichannel_biquad_df2_filter #(
    parameter int CHANNELS    = 8,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    output logic                                  req_stall,
    input  logic signed [SAMPLE_BITS-1:0]         sample_in,
    input  logic [mcbq_pkg::SEL_W-1:0]            channel_sel,
    output logic                                  rsp_valid,
    input  logic                                  rsp_stall,
    output logic signed [SAMPLE_BITS-1:0]         sample_out,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mcbq_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mcbq_pkg::COEF_W-1:0]           cfg_data
);

    localparam int AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ACC_W  = mcbq_pkg::ACC_W;
    localparam int CONV_W = mcbq_pkg::CONV_W;
    localparam int CW     = mcbq_pkg::COEF_W;

    function automatic logic [AW-1:0] wrap_channel(input logic [mcbq_pkg::SEL_W-1:0] sel);
        logic [mcbq_pkg::SEL_W-1:0] v;
        v = sel;
        for (int i = 0; i < 7; i++)
        begin
            if (int'(v) >= CHANNELS)
            begin
                v = v - mcbq_pkg::SEL_W'(CHANNELS);
            end
        end
        return AW'(v);
    endfunction

    mcbq_pkg::state_t state_reg, state_next;

    logic signed [CW-1:0] coef_b0_reg, coef_b1_reg, coef_b2_reg, coef_a1_reg, coef_a2_reg;

    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic [AW-1:0]                 ch_reg;
    logic signed [CW-1:0]          w_reg, w_next;
    logic signed [ACC_W-1:0]       acc_reg, acc_next;
    logic signed [mcbq_pkg::PROD_W-1:0] m0_reg, m1_reg;
    logic signed [CW-1:0]          mul0_a, mul0_b, mul1_a, mul1_b;
    logic                          rsp_valid_reg, rsp_valid_next;
    logic signed [SAMPLE_BITS-1:0] sample_out_reg, y_sat;

    logic                 req_acc, out_free, load_out;
    mcbq_pkg::mem_ctl_t   mem_ctl;
    logic [63:0]          rd_data;
    logic signed [CW-1:0] w1, w2;

    logic signed [ACC_W-1:0]  xq, w_sum, y_sum;
    logic signed [CONV_W-1:0] y_conv;
    logic                     w_fits, y_fits;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_b0_reg <= mcbq_pkg::B0_RESET;
            coef_b1_reg <= '0;
            coef_b2_reg <= '0;
            coef_a1_reg <= '0;
            coef_a2_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mcbq_pkg::REG_B0: coef_b0_reg <= cfg_data;
                mcbq_pkg::REG_B1: coef_b1_reg <= cfg_data;
                mcbq_pkg::REG_B2: coef_b2_reg <= cfg_data;
                mcbq_pkg::REG_A1: coef_a1_reg <= cfg_data;
                mcbq_pkg::REG_A2: coef_a2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign load_out  = (state_reg == mcbq_pkg::ST_OUT) && out_free;
    assign req_stall = !((state_reg == mcbq_pkg::ST_IDLE) || load_out);
    assign req_acc   = req_valid && !req_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mcbq_pkg::ST_IDLE:
            begin
                if (req_acc)
                begin
                    state_next = mcbq_pkg::ST_FB;
                end
            end
            mcbq_pkg::ST_FB:  state_next = mcbq_pkg::ST_W;
            mcbq_pkg::ST_W:   state_next = mcbq_pkg::ST_FF;
            mcbq_pkg::ST_FF:  state_next = mcbq_pkg::ST_OUT;
            mcbq_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = req_acc ? mcbq_pkg::ST_FB : mcbq_pkg::ST_IDLE;
                end
            end
            default: state_next = mcbq_pkg::ST_IDLE;
        endcase
    end

    assign mem_ctl.rd_en = req_acc;
    assign mem_ctl.wr_en = (state_reg == mcbq_pkg::ST_FF);

    mcbq_state_ram #(
        .CHANNELS (CHANNELS),
        .AW       (AW)
    ) u_state_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mem_ctl),
        .rd_addr (wrap_channel(channel_sel)),
        .wr_addr (ch_reg),
        .wr_data ({w_reg, w1}),
        .rd_data (rd_data)
    );

    assign w1 = rd_data[63:32];
    assign w2 = rd_data[31:0];

    always_comb
    begin
        unique case (state_reg)
            mcbq_pkg::ST_FB:
            begin
                mul0_a = coef_a1_reg;
                mul0_b = w1;
                mul1_a = coef_a2_reg;
                mul1_b = w2;
            end
            mcbq_pkg::ST_W:
            begin
                mul0_a = coef_b1_reg;
                mul0_b = w1;
                mul1_a = coef_b2_reg;
                mul1_b = w2;
            end
            default:
            begin
                mul0_a = coef_b0_reg;
                mul0_b = w_reg;
                mul1_a = coef_b2_reg;
                mul1_b = w2;
            end
        endcase
    end

    generate
        if (SAMPLE_BITS <= 25)
        begin : g_x_up
            localparam int XUP = 25 - SAMPLE_BITS;
            assign xq = {{(ACC_W-SAMPLE_BITS){x_reg[SAMPLE_BITS-1]}}, x_reg} <<< XUP;
        end
        else
        begin : g_x_down
            localparam int XDN = SAMPLE_BITS - 25;
            assign xq = {{(ACC_W-25){x_reg[SAMPLE_BITS-1]}}, x_reg[SAMPLE_BITS-1:XDN]};
        end
    endgenerate

    assign w_sum  = xq - mcbq_pkg::round_q24(m0_reg) - mcbq_pkg::round_q24(m1_reg);
    assign w_fits = (w_sum[ACC_W-1:CW-1] == {(ACC_W-CW+1){w_sum[CW-1]}});

    always_comb
    begin
        priority if (w_fits)
        begin
            w_next = w_sum[CW-1:0];
        end
        else if (w_sum[ACC_W-1])
        begin
            w_next = {1'b1, {(CW-1){1'b0}}};
        end
        else
        begin
            w_next = {1'b0, {(CW-1){1'b1}}};
        end
    end

    assign acc_next = mcbq_pkg::round_q24(m0_reg) + mcbq_pkg::round_q24(m1_reg);
    assign y_sum    = acc_reg + mcbq_pkg::round_q24(m0_reg);

    generate
        if (SAMPLE_BITS == 25)
        begin : g_y_same
            assign y_conv = {{(CONV_W-ACC_W){y_sum[ACC_W-1]}}, y_sum};
        end
        else if (SAMPLE_BITS < 25)
        begin : g_y_down
            localparam int YSH = 25 - SAMPLE_BITS;
            localparam logic signed [ACC_W-1:0] Y_HALF = ACC_W'(1) << (YSH - 1);
            logic signed [ACC_W-1:0] y_tmp;
            assign y_tmp  = y_sum + Y_HALF;
            assign y_conv = {{(CONV_W-ACC_W+YSH){y_tmp[ACC_W-1]}}, y_tmp[ACC_W-1:YSH]};
        end
        else
        begin : g_y_up
            localparam int YUP = SAMPLE_BITS - 25;
            assign y_conv = {{(CONV_W-ACC_W){y_sum[ACC_W-1]}}, y_sum} <<< YUP;
        end
    endgenerate

    assign y_fits = (y_conv[CONV_W-1:SAMPLE_BITS-1]
                     == {(CONV_W-SAMPLE_BITS+1){y_conv[SAMPLE_BITS-1]}});

    always_comb
    begin
        priority if (y_fits)
        begin
            y_sat = y_conv[SAMPLE_BITS-1:0];
        end
        else if (y_conv[CONV_W-1])
        begin
            y_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            y_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    always_comb
    begin
        priority if (load_out)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mcbq_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            x_reg  <= sample_in;
            ch_reg <= wrap_channel(channel_sel);
        end
        if ((state_reg == mcbq_pkg::ST_FB) || (state_reg == mcbq_pkg::ST_W)
            || (state_reg == mcbq_pkg::ST_FF))
        begin
            m0_reg <= mul0_a * mul0_b;
            m1_reg <= mul1_a * mul1_b;
        end
        if (state_reg == mcbq_pkg::ST_W)
        begin
            w_reg <= w_next;
        end
        if (state_reg == mcbq_pkg::ST_FF)
        begin
            acc_reg <= acc_next;
        end
        if (load_out)
        begin
            sample_out_reg <= y_sat;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign sample_out = sample_out_reg;

    `MCBQ_ASSERT_NEXT(a_accept_starts_work, req_acc, state_reg == mcbq_pkg::ST_FB,
        "accepted sample did not start the feedback step")
    `MCBQ_ASSERT_SAME(a_result_from_last_step, $rose(rsp_valid),
        $past(state_reg) == mcbq_pkg::ST_OUT, "result appeared outside the last step")
    `MCBQ_ASSERT_NEXT(a_blocked_result_waits,
        (state_reg == mcbq_pkg::ST_OUT) && rsp_valid && rsp_stall,
        state_reg == mcbq_pkg::ST_OUT, "finished result left while output was blocked")

endmodule

// ===== src/mcbq_state_ram.sv =====
// ----------------------------------------------------------------------------
// mcbq_state_ram
// Per-channel delay word memory with registered read.
// Entries that were never written since reset read as zero.
// ----------------------------------------------------------------------------
module mcbq_state_ram #(
    parameter int CHANNELS = 8,
    parameter int AW = 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mcbq_pkg::mem_ctl_t   ctl,
    input  logic [AW-1:0]        rd_addr,
    input  logic [AW-1:0]        wr_addr,
    input  logic [63:0]          wr_data,
    output logic [63:0]          rd_data
);

    logic [63:0]         mem [CHANNELS];
    logic [CHANNELS-1:0] written_reg;
    logic [63:0]         rd_data_reg;
    logic                rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_vld_reg <= written_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : 64'd0;

endmodule

// ===== tb/tb_multichannel_biquad_df2_filter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for multichannel_biquad_df2_filter
// Drives sample transactions on eight channels and checks every filtered
// sample against a fixed-point direct form II biquad predictor in the bench
// or a fixed value from a short table. The table covers the field extremes,
// coefficient extremes, saturation and ignored register indexes. Random
// phases follow, each with new coefficients written while the filter is idle.
// ----------------------------------------------------------------------------
module tb_multichannel_biquad_df2_filter;

    localparam int CHANNELS = 8;
    localparam int SAMPLE_BITS = 24;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_SAMPLES = 104;
    localparam int DRAIN_CYCLES = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [mcbq_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam logic [mcbq_pkg::COEF_W-1:0] COEF_MAX = 32'h7FFF_FFFF;
    localparam logic [mcbq_pkg::COEF_W-1:0] COEF_MIN = 32'h8000_0000;
    localparam logic [mcbq_pkg::COEF_W-1:0] COEF_ONE = 32'h0100_0000;
    localparam logic [SAMPLE_BITS-1:0] SMP_MAX = 24'h7F_FFFF;
    localparam logic [SAMPLE_BITS-1:0] SMP_MIN = 24'h80_0000;
    localparam logic [SAMPLE_BITS-1:0] SMP_NEG1 = 24'hFF_FFFF;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_COEF
    } row_kind_t;

    typedef struct packed {
        row_kind_t                            kind;
        logic [mcbq_pkg::CFG_IDX_W-1:0]       idx;
        logic [mcbq_pkg::COEF_W-1:0]          coef;
        logic [SAMPLE_BITS-1:0]               smp;
        logic [mcbq_pkg::SEL_W-1:0]           chan;
        logic                                 fixed;
        logic [SAMPLE_BITS-1:0]               want;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 32;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    logic signed [SAMPLE_BITS-1:0] sample_in = '0;
    logic [mcbq_pkg::SEL_W-1:0] channel_sel = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [mcbq_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [mcbq_pkg::COEF_W-1:0] cfg_data = '0;

    logic signed [mcbq_pkg::COEF_W-1:0] coef_now [0:4] =
        '{32'sd16777216, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
    logic signed [mcbq_pkg::COEF_W-1:0] delay_one [0:CHANNELS-1] = '{default: '0};
    logic signed [mcbq_pkg::COEF_W-1:0] delay_two [0:CHANNELS-1] = '{default: '0};
    logic signed [SAMPLE_BITS-1:0] out_expected [$];

    int err_count = 0;
    int quiet_cycles = 0;
    int stall_left = 0;
    bit req_gaps = 1'b1;
    bit rsp_stalls = 1'b1;

    stim_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
        '{ROW_SAMPLE, mcbq_pkg::REG_B0, 32'h0, 24'h0, 3'd0, 1'b1, 24'h0},
        '{ROW_SAMPLE, mcbq_pkg::REG_B0, 32'h0, SMP_MAX, 3'd7, 1'b1, SMP_MAX},
        '{ROW_SAMPLE, mcbq_pkg::REG_B0, 32'h0, SMP_MIN, 3'd3, 1'b1, SMP_MIN},
        '{ROW_SAMPLE, mcbq_pkg::REG_B0, 32'h0, 24'h1, 3'd1, 1'b1, 24'h1},
        '{ROW_SAMPLE, mcbq_pkg::REG_B0, 32'h0, SMP_NEG1, 3'd2, 1'b1, SMP_NEG1},
        '{ROW_COEF, mcbq_pkg::REG_B0, COEF_MAX, 24'h0, 3'd0, 1'b0, 24'h0},
        '{ROW_SAMPLE, mcbq_pkg::REG_B0, 32'h0, SMP_MAX, 3'd0, 1'b1, SMP_MAX},
        '{ROW_SAMPLE, mcbq_pkg::REG_B0, 32'h0, SMP_MIN, 3'd5, 1'b1, SMP_MIN},
        '{ROW_SAMPLE, mcbq_pkg::REG_B0, 32'h0, 24'h0, 3'd6, 1'b1, 24'h0},
        '{ROW_COEF, mcbq_pkg::REG_B0, COEF_MIN, 24'h0, 3'd0, 1'b0, 24'h0},
        '{ROW_SAMPLE, mcbq_pkg::REG_B0, 32'h0, SMP_MAX, 3'd1, 1'b1, SMP_MIN},
        '{ROW_SAMPLE, mcbq_pkg::REG_B0, 32'h0, SMP_MIN, 3'd2, 1'b1, SMP_MAX},
        '{ROW_COEF, REG_SPARE, 32'h0, 24'h0, 3'd0, 1'b0, 24'h0},
        '{ROW_SAMPLE, mcbq_pkg::REG_B0, 32'h0, 24'h1, 3'd3, 1'b0, 24'h0},
        '{ROW_COEF, mcbq_pkg::REG_B0, COEF_ONE, 24'h0, 3'd0, 1'b0, 24'h0},
        '{ROW_COEF, mcbq_pkg::REG_B1, COEF_MAX, 24'h0, 3'd0, 1'b0, 24'h0},
        '{ROW_COEF, mcbq_pkg::REG_B2, COEF_MIN, 24'h0, 3'd0, 1'b0, 24'h0},
        '{ROW_COEF, mcbq_pkg::REG_A1, COEF_MIN, 24'h0, 3'd0, 1'b0, 24'h0},
        '{ROW_COEF, mcbq_pkg::REG_A2, COEF_MAX, 24'h0, 3'd0, 1'b0, 24'h0},
        '{ROW_SAMPLE, mcbq_pkg::REG_B0, 32'h0, SMP_MAX, 3'd4, 1'b0, 24'h0},
        '{ROW_SAMPLE, mcbq_pkg::REG_B0, 32'h0, SMP_MAX, 3'd4, 1'b0, 24'h0},
        '{ROW_SAMPLE, mcbq_pkg::REG_B0, 32'h0, SMP_MAX, 3'd4, 1'b0, 24'h0},
        '{ROW_SAMPLE, mcbq_pkg::REG_B0, 32'h0, SMP_MIN, 3'd4, 1'b0, 24'h0},
        '{ROW_SAMPLE, mcbq_pkg::REG_B0, 32'h0, 24'h12_3456, 3'd6, 1'b0, 24'h0},
        '{ROW_COEF, mcbq_pkg::REG_B0, 32'h0080_0000, 24'h0, 3'd0, 1'b0, 24'h0},
        '{ROW_COEF, mcbq_pkg::REG_B1, 32'h0, 24'h0, 3'd0, 1'b0, 24'h0},
        '{ROW_COEF, mcbq_pkg::REG_B2, 32'h0, 24'h0, 3'd0, 1'b0, 24'h0},
        '{ROW_COEF, mcbq_pkg::REG_A1, 32'h0, 24'h0, 3'd0, 1'b0, 24'h0},
        '{ROW_COEF, mcbq_pkg::REG_A2, 32'h0, 24'h0, 3'd0, 1'b0, 24'h0},
        '{ROW_SAMPLE, mcbq_pkg::REG_B0, 32'h0, 24'h1, 3'd0, 1'b0, 24'h0},
        '{ROW_SAMPLE, mcbq_pkg::REG_B0, 32'h0, SMP_NEG1, 3'd0, 1'b0, 24'h0},
        '{ROW_SAMPLE, mcbq_pkg::REG_B0, 32'h0, 24'h3, 3'd7, 1'b0, 24'h0}
    };

    multichannel_biquad_df2_filter #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .sample_in   (sample_in),
        .channel_sel (channel_sel),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .sample_out  (sample_out),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic logic signed [63:0] scaled_product(
        input logic signed [mcbq_pkg::COEF_W-1:0] c,
        input logic signed [mcbq_pkg::COEF_W-1:0] d
    );
        logic signed [63:0] p;
        p = $signed({{32{c[mcbq_pkg::COEF_W-1]}}, c})
            * $signed({{32{d[mcbq_pkg::COEF_W-1]}}, d});
        return (p + 64'sd8388608) >>> 24;
    endfunction

    function automatic logic signed [63:0] clamp(input logic signed [63:0] v, input int bits);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] biquad_step(
        input logic signed [SAMPLE_BITS-1:0] x,
        input logic [mcbq_pkg::SEL_W-1:0] ch
    );
        int idx;
        int s;
        logic signed [mcbq_pkg::COEF_W-1:0] w1;
        logic signed [mcbq_pkg::COEF_W-1:0] w2;
        logic signed [63:0] xq;
        logic signed [63:0] w;
        logic signed [63:0] y;
        idx = int'(ch) % CHANNELS;
        s = 25 - SAMPLE_BITS;
        w1 = delay_one[idx];
        w2 = delay_two[idx];
        xq = 64'(x);
        xq = xq <<< s;
        w = clamp(xq - scaled_product(coef_now[mcbq_pkg::REG_A1], w1)
                     - scaled_product(coef_now[mcbq_pkg::REG_A2], w2), 32);
        y = scaled_product(coef_now[mcbq_pkg::REG_B0], w[mcbq_pkg::COEF_W-1:0])
          + scaled_product(coef_now[mcbq_pkg::REG_B1], w1)
          + scaled_product(coef_now[mcbq_pkg::REG_B2], w2);
        y = (y + (64'sd1 <<< (s - 1))) >>> s;
        y = clamp(y, SAMPLE_BITS);
        delay_two[idx] = w1;
        delay_one[idx] = w[mcbq_pkg::COEF_W-1:0];
        return y[SAMPLE_BITS-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp,
                               input logic [mcbq_pkg::SEL_W-1:0] ch,
                               input logic fixed, input logic [SAMPLE_BITS-1:0] want);
        logic signed [SAMPLE_BITS-1:0] predicted;
        req_valid <= 1'b1;
        sample_in <= smp;
        channel_sel <= ch;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted = biquad_step(smp, ch);
        out_expected.push_back(fixed ? $signed(want) : predicted);
        if (req_gaps && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic write_coef(input logic [mcbq_pkg::CFG_IDX_W-1:0] idx,
                              input logic [mcbq_pkg::COEF_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx <= mcbq_pkg::REG_A2)
            coef_now[idx] = val;
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (out_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            rsp_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (rsp_stalls && $urandom_range(0, 5) == 0)
        begin
            rsp_stall <= 1'b1;
            stall_left <= $urandom_range(0, 3);
        end
        else
        begin
            rsp_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        logic signed [SAMPLE_BITS-1:0] want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (out_expected.size() == 0)
            begin
                report_mismatch($sformatf("sample_out %0d with no sample pending", sample_out));
            end
            else
            begin
                want = out_expected.pop_front();
                if (sample_out !== want)
                    report_mismatch($sformatf("sample_out got %0d, expected %0d",
                                              sample_out, want));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        logic [mcbq_pkg::COEF_W-1:0] new_coefs [0:4];
        logic [SAMPLE_BITS-1:0] smp;
        logic [mcbq_pkg::SEL_W-1:0] ch;
        int a2i;
        int lim;
        int style;
        int pick;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_COEF)
            begin
                wait_drained();
                write_coef(directed_rows[i].idx, directed_rows[i].coef);
                cfg_valid <= 1'b0;
            end
            else
            begin
                send_sample(directed_rows[i].smp, directed_rows[i].chan,
                            directed_rows[i].fixed, directed_rows[i].want);
            end
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_drained();
            req_gaps = (p != 3) && (p != RANDOM_PHASES - 1);
            rsp_stalls = req_gaps;
            style = (p == 2) ? 1 : (p == 5) ? 2 : 0;
            for (int r = mcbq_pkg::REG_B0; r <= mcbq_pkg::REG_A2; r++)
            begin
                if (style == 1)
                begin
                    new_coefs[r] = $urandom;
                end
                else if (style == 2)
                begin
                    case ($urandom_range(0, 3))
                        0: new_coefs[r] = COEF_MAX;
                        1: new_coefs[r] = COEF_MIN;
                        2: new_coefs[r] = '0;
                        default: new_coefs[r] = COEF_ONE;
                    endcase
                end
                else
                begin
                    new_coefs[r] = int'($urandom_range(0, 33554432)) - 16777216;
                end
            end
            if (style == 0)
            begin
                a2i = int'($urandom_range(0, 30198988)) - 15099494;
                lim = ((16777216 + a2i) / 20) * 19;
                new_coefs[mcbq_pkg::REG_A2] = a2i;
                new_coefs[mcbq_pkg::REG_A1] = int'($urandom_range(0, 2 * lim)) - lim;
            end
            for (int r = mcbq_pkg::REG_B0; r <= mcbq_pkg::REG_A2; r++)
                write_coef(mcbq_pkg::CFG_IDX_W'(r), new_coefs[r]);
            if ($urandom_range(0, 1) == 1)
                write_coef(mcbq_pkg::CFG_IDX_W'($urandom_range(mcbq_pkg::REG_A2 + 1, REG_SPARE)),
                           $urandom);
            cfg_valid <= 1'b0;

            ch = mcbq_pkg::SEL_W'($urandom_range(0, CHANNELS - 1));
            for (int k = 0; k < PHASE_SAMPLES; k++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    smp = SAMPLE_BITS'($urandom);
                else if (pick < 8)
                    smp = SAMPLE_BITS'(int'($urandom_range(0, 255)) - 128);
                else if (pick == 8)
                    smp = $urandom_range(0, 1) ? SMP_MAX : SMP_MIN;
                else
                    smp = SAMPLE_BITS'(int'($urandom_range(0, 2)) - 1);
                if ($urandom_range(0, 2) != 0)
                    ch = mcbq_pkg::SEL_W'($urandom_range(0, CHANNELS - 1));
                send_sample(smp, ch, 1'b0, '0);
            end
        end

        wait_drained();
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
